FILE: rtl/boot_keyboard_report_event_decoder_assert.svh
// Assertion macros shared by the boot keyboard report decoder RTL.
// Included by modules that check their own logic; depends on nothing else.
`ifndef BOOT_KEYBOARD_REPORT_EVENT_DECODER_ASSERT_SVH
`define BOOT_KEYBOARD_REPORT_EVENT_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BKRD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bkrd: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BKRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bkrd: next-cycle check failed");

`endif

FILE: rtl/bkrd_pkg.sv
// Package for the boot keyboard report decoder: event kinds, result type
// and fixed report constants. Depends on nothing.
package bkrd_pkg;

  localparam int MIN_REPORT_BYTES = 8;
  localparam int INPUT_BYTES      = 9;
  localparam int MOD_BITS         = 8;

  typedef enum logic [1:0] {
    KIND_MODIFIER     = 2'd0,
    KIND_KEY          = 2'd1,
    KIND_UNRECOGNIZED = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] code;
    logic       pressed;
    logic       last;
  } event_t;

endpackage

FILE: rtl/bkrd_report_if.sv
// Handshake channel that carries one keyboard report transaction.
// Standalone; used by the decoder's input port.
interface bkrd_report_if;
  logic       valid;
  logic       ready;
  logic [7:0] report_length;
  logic [7:0] byte_0;
  logic [7:0] byte_1;
  logic [7:0] byte_2;
  logic [7:0] byte_3;
  logic [7:0] byte_4;
  logic [7:0] byte_5;
  logic [7:0] byte_6;
  logic [7:0] byte_7;
  logic [7:0] byte_8;

  modport source (
    output valid, report_length, byte_0, byte_1, byte_2, byte_3, byte_4,
           byte_5, byte_6, byte_7, byte_8,
    input  ready
  );
  modport sink (
    input  valid, report_length, byte_0, byte_1, byte_2, byte_3, byte_4,
           byte_5, byte_6, byte_7, byte_8,
    output ready
  );
endinterface

FILE: rtl/bkrd_event_if.sv
// Handshake channel that carries one key or modifier event transaction.
// Standalone; used by the decoder's output port.
interface bkrd_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] event_code;
  logic       pressed;
  logic       last_event;

  modport source (
    output valid, event_kind, event_code, pressed, last_event,
    input  ready
  );
  modport sink (
    input  valid, event_kind, event_code, pressed, last_event,
    output ready
  );
endinterface

FILE: rtl/bkrd_cmd_fifo.sv
// Small command queue between the report front end and the event engine.
// Uses the assertion header; no package dependency.
`include "boot_keyboard_report_event_decoder_assert.svh"

module bkrd_cmd_fifo #(
  parameter int WIDTH = 57,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DEPTH-1:0][WIDTH-1:0] mem;
  logic [PTR_W-1:0]            wr_ptr;
  logic [PTR_W-1:0]            rd_ptr;
  logic [CNT_W-1:0]            count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  `BKRD_ASSERT_NOW(a_count_range, clk, rst, 1'b1, count <= CNT_W'(DEPTH))
  `BKRD_ASSERT_NOW(a_pop_nonempty, clk, rst, pop, count != '0)
  `BKRD_ASSERT_NOW(a_push_room, clk, rst, push && !pop, !full)

endmodule

FILE: rtl/bkrd_front.sv
// Front end: takes a report transaction, checks its length, finds the
// modifier byte and key slots, and registers the result as a command.
// Depends on bkrd_pkg and bkrd_report_if.
module bkrd_front #(
  parameter int KEY_SLOTS = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  bkrd_report_if.sink               report,
  input  logic                      fifo_full,
  output logic                      push,
  output logic                      cmd_bad,
  output logic [7:0]                cmd_mods,
  output logic [KEY_SLOTS-1:0][7:0] cmd_keys
);

  logic                                     cmd_valid;
  logic [bkrd_pkg::INPUT_BYTES-1:0][7:0]    bytes_in;
  logic                                     short_report;
  logic                                     has_id;
  logic [7:0]                               mods_in;
  logic [KEY_SLOTS-1:0][7:0]                keys_in;
  logic [4:0]                               idx;

  assign bytes_in = {report.byte_8, report.byte_7, report.byte_6, report.byte_5,
                     report.byte_4, report.byte_3, report.byte_2, report.byte_1,
                     report.byte_0};

  assign push         = cmd_valid && !fifo_full;
  assign report.ready = !cmd_valid || !fifo_full;

  // A long report carries a report ID unless the reserved byte is nonzero.
  assign short_report = report.report_length < 8'(bkrd_pkg::MIN_REPORT_BYTES);
  assign has_id       = (report.report_length >= 8'(bkrd_pkg::INPUT_BYTES)) &&
                        (report.byte_2 == 8'd0);
  assign mods_in      = has_id ? report.byte_1 : report.byte_0;

  always_comb begin
    idx     = '0;
    keys_in = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      idx = 5'(i) + 5'd2 + {4'd0, has_id};
      if (idx < 5'(bkrd_pkg::INPUT_BYTES)) begin
        keys_in[i] = bytes_in[idx[3:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (report.valid && report.ready) begin
      cmd_valid <= 1'b1;
    end else if (push) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (report.valid && report.ready) begin
      cmd_bad  <= short_report;
      cmd_mods <= mods_in;
      cmd_keys <= keys_in;
    end
  end

endmodule

FILE: rtl/bkrd_back.sv
// Event engine: holds the previous modifiers and key set, compares each
// queued command with them and sends one event per cycle unless stalled.
// Depends on bkrd_pkg, bkrd_event_if and the assertion header.
`include "boot_keyboard_report_event_decoder_assert.svh"

module bkrd_back #(
  parameter int KEY_SLOTS = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      head_valid,
  input  logic                      head_bad,
  input  logic [7:0]                head_mods,
  input  logic [KEY_SLOTS-1:0][7:0] head_keys,
  output logic                      pop,
  bkrd_event_if.source              events
);

  logic                      active;
  logic                      active_next;
  logic                      bad;
  logic                      bad_next;
  logic [7:0]                prev_mods;
  logic [7:0]                prev_mods_next;
  logic [7:0]                mod_mask;
  logic [7:0]                mod_mask_next;
  logic [KEY_SLOTS-1:0][7:0] held;
  logic [KEY_SLOTS-1:0][7:0] held_next;
  logic [KEY_SLOTS-1:0][7:0] old_keys;
  logic [KEY_SLOTS-1:0][7:0] old_keys_next;
  logic [KEY_SLOTS-1:0]      down_mask;
  logic [KEY_SLOTS-1:0]      down_mask_next;
  logic [KEY_SLOTS-1:0]      up_mask;
  logic [KEY_SLOTS-1:0]      up_mask_next;
  logic                      out_valid;
  logic                      out_valid_next;
  bkrd_pkg::event_t          out_event;
  bkrd_pkg::event_t          out_event_next;

  logic                      advance;
  logic                      fire;
  logic                      fire_last;
  logic [KEY_SLOTS-1:0]      load_down;
  logic [KEY_SLOTS-1:0]      load_up;
  logic [2:0]                mod_bit;
  logic [7:0]                mod_rest;
  logic                      use_down;
  logic [KEY_SLOTS-1:0][7:0] sel_vals;
  logic [KEY_SLOTS-1:0]      sel_mask;
  logic [KEY_SLOTS-1:0]      win;
  logic [KEY_SLOTS-1:0]      sel_rest;
  logic [7:0]                sel_code;

  assign advance = !out_valid || events.ready;
  assign fire    = active && advance;

  assign events.valid      = out_valid;
  assign events.event_kind = out_event.kind;
  assign events.event_code = out_event.code;
  assign events.pressed    = out_event.pressed;
  assign events.last_event = out_event.last;

  // New keys are those absent from the held set; released keys are held
  // ones absent from the new report.
  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      load_down[i] = (head_keys[i] != 8'd0);
      load_up[i]   = (held[i] != 8'd0);
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (held[j] == head_keys[i]) begin
          load_down[i] = 1'b0;
        end
        if (head_keys[j] == held[i]) begin
          load_up[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    mod_bit = '0;
    for (int i = bkrd_pkg::MOD_BITS - 1; i >= 0; i--) begin
      if (mod_mask[i]) begin
        mod_bit = 3'(i);
      end
    end
    mod_rest = mod_mask & (mod_mask - 8'd1);
  end

  // Smallest pending usage wins; every slot with the same value is retired
  // with it, which removes duplicates.
  always_comb begin
    use_down = (down_mask != '0);
    sel_vals = use_down ? held : old_keys;
    sel_mask = use_down ? down_mask : up_mask;
    sel_code = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      win[i] = sel_mask[i];
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (sel_mask[j] && ((sel_vals[j] < sel_vals[i]) ||
            ((sel_vals[j] == sel_vals[i]) && (j < i)))) begin
          win[i] = 1'b0;
        end
      end
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (win[i]) begin
        sel_code = sel_code | sel_vals[i];
      end
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      sel_rest[i] = sel_mask[i] && (sel_vals[i] != sel_code);
    end
  end

  always_comb begin
    active_next    = active;
    bad_next       = bad;
    prev_mods_next = prev_mods;
    mod_mask_next  = mod_mask;
    held_next      = held;
    old_keys_next  = old_keys;
    down_mask_next = down_mask;
    up_mask_next   = up_mask;
    out_valid_next = out_valid && !events.ready;
    out_event_next = out_event;
    fire_last      = 1'b0;
    pop            = 1'b0;
    if (!active && head_valid) begin
      pop = 1'b1;
      if (head_bad) begin
        active_next = 1'b1;
        bad_next    = 1'b1;
      end else begin
        mod_mask_next  = head_mods ^ prev_mods;
        down_mask_next = load_down;
        up_mask_next   = load_up;
        prev_mods_next = head_mods;
        held_next      = head_keys;
        old_keys_next  = held;
        active_next    = ((head_mods ^ prev_mods) != 8'd0) || (load_down != '0) ||
                         (load_up != '0);
      end
    end else if (fire) begin
      out_valid_next = 1'b1;
      if (bad) begin
        fire_last              = 1'b1;
        bad_next               = 1'b0;
        out_event_next.kind    = bkrd_pkg::KIND_UNRECOGNIZED;
        out_event_next.code    = 8'd0;
        out_event_next.pressed = 1'b0;
      end else if (mod_mask != 8'd0) begin
        fire_last              = (mod_rest == 8'd0) && (down_mask == '0) &&
                                 (up_mask == '0);
        mod_mask_next          = mod_rest;
        out_event_next.kind    = bkrd_pkg::KIND_MODIFIER;
        out_event_next.code    = {5'd0, mod_bit};
        out_event_next.pressed = prev_mods[mod_bit];
      end else if (use_down) begin
        fire_last              = (sel_rest == '0) && (up_mask == '0);
        down_mask_next         = sel_rest;
        out_event_next.kind    = bkrd_pkg::KIND_KEY;
        out_event_next.code    = sel_code;
        out_event_next.pressed = 1'b1;
      end else begin
        fire_last              = (sel_rest == '0);
        up_mask_next           = sel_rest;
        out_event_next.kind    = bkrd_pkg::KIND_KEY;
        out_event_next.code    = sel_code;
        out_event_next.pressed = 1'b0;
      end
      out_event_next.last = fire_last;
      active_next         = !fire_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      bad       <= 1'b0;
      prev_mods <= 8'd0;
      held      <= '0;
      mod_mask  <= 8'd0;
      down_mask <= '0;
      up_mask   <= '0;
      out_valid <= 1'b0;
    end else begin
      active    <= active_next;
      bad       <= bad_next;
      prev_mods <= prev_mods_next;
      held      <= held_next;
      mod_mask  <= mod_mask_next;
      down_mask <= down_mask_next;
      up_mask   <= up_mask_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    old_keys  <= old_keys_next;
    out_event <= out_event_next;
  end

  `BKRD_ASSERT_NOW(a_unrec_last, clk, rst, out_valid && (out_event.kind == bkrd_pkg::KIND_UNRECOGNIZED), out_event.last && (out_event.code == 8'd0))
  `BKRD_ASSERT_NOW(a_active_has_work, clk, rst, active && !bad, (mod_mask != 8'd0) || (down_mask != '0) || (up_mask != '0))
  `BKRD_ASSERT_NEXT(a_mods_first, clk, rst, fire && !bad && (mod_mask != 8'd0), out_valid && (out_event.kind == bkrd_pkg::KIND_MODIFIER))
  `BKRD_ASSERT_NEXT(a_last_ends, clk, rst, fire && fire_last, !active)

endmodule

FILE: rtl/boot_keyboard_report_event_decoder.sv
// Top level of the boot keyboard report decoder: front end, command queue
// and event engine. Depends on bkrd_pkg, both channel interfaces and the
// bkrd_front, bkrd_cmd_fifo and bkrd_back modules.
//
//  Channel  Dir  Transaction                 Fields
//  report   in   one keyboard input report   report_length, byte_0 .. byte_8
//  events   out  one modifier or key event   event_kind, event_code, pressed,
//                                            last_event
//
// A report is held in the front register and then waits in a
// two-entry queue. The engine loads it and then sends one event per cycle
// while the output does not stall. An unchanged report sends no event.
// Reset (rst, synchronous) clears the modifiers, the held keys and the queue.
// An output stall holds the engine along with its output register, except
// that the next report may load once the last event of the current one waits.
module boot_keyboard_report_event_decoder #(
  parameter int KEY_SLOTS = 6
) (
  input  logic          clk,
  input  logic          rst,
  bkrd_report_if.sink   report,
  bkrd_event_if.source  events
);

  // One queued command: short-report flag, modifier byte and key slots.
  localparam int CMD_W      = 1 + 8 + 8 * KEY_SLOTS;
  localparam int QUEUE_DEPTH = 2;

  logic                      push;
  logic                      fifo_full;
  logic                      cmd_bad;
  logic [7:0]                cmd_mods;
  logic [KEY_SLOTS-1:0][7:0] cmd_keys;
  logic [CMD_W-1:0]          push_data;
  logic                      pop;
  logic                      head_valid;
  logic [CMD_W-1:0]          head_data;
  logic                      head_bad;
  logic [7:0]                head_mods;
  logic [KEY_SLOTS-1:0][7:0] head_keys;

  bkrd_front #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .report    (report),
    .fifo_full (fifo_full),
    .push      (push),
    .cmd_bad   (cmd_bad),
    .cmd_mods  (cmd_mods),
    .cmd_keys  (cmd_keys)
  );

  assign push_data = {cmd_bad, cmd_mods, cmd_keys};

  bkrd_cmd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (fifo_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  assign {head_bad, head_mods, head_keys} = head_data;

  bkrd_back #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_bad   (head_bad),
    .head_mods  (head_mods),
    .head_keys  (head_keys),
    .pop        (pop),
    .events     (events)
  );

endmodule
